// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the periodic gradient energy block.
// Every check is sampled on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define PG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The expression must never be true at a sampled edge.
`define PG_ASSERT_NEVER(lbl, expr, msg) \
   `PG_ASSERT(lbl, !(expr), msg)

`endif

// ----- rtl/core/pgrad_pkg.sv -----
// Package for the periodic gradient energy block: grid sizes, widths, types and tables.
// It has no dependencies; the top level, pgrad_addr and pgrad_accum import it.
package pgrad_pkg;

   localparam int unsigned GRID_X = 64;
   localparam int unsigned GRID_Y = 64;
   localparam int unsigned GRID_Z = 64;

   localparam int unsigned POS_W    = 6;
   localparam int unsigned POS_N    = 1 << POS_W;
   localparam int unsigned VAL_W    = 16;
   localparam int unsigned WORD_W   = 2 * VAL_W;
   localparam int unsigned DIFF_W   = VAL_W + 1;
   localparam int unsigned SQ_W     = 2 * VAL_W;
   localparam int unsigned ACC_W    = SQ_W + 3;
   localparam int unsigned ENERGY_W = 33;
   localparam int unsigned ROUND_ADD = 2;
   localparam int unsigned FRAC_DROP = 2;

   localparam int unsigned XW     = $clog2(GRID_X);
   localparam int unsigned YW     = $clog2(GRID_Y);
   localparam int unsigned ZW     = $clog2(GRID_Z);
   localparam int unsigned CELLS  = GRID_X * GRID_Y * GRID_Z;
   localparam int unsigned AW     = $clog2(CELLS);
   localparam int unsigned ROW_W  = $clog2(GRID_X * GRID_Z);

   localparam int unsigned NUM_READS = 6;
   localparam int unsigned NUM_PAIRS = NUM_READS / 2;
   localparam int unsigned PAIR_W    = $clog2(NUM_PAIRS);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [7:0] coord_tab_type [0:POS_N-1];

   // Coordinate reduction table: entry i holds i modulo the grid size.
   function automatic coord_tab_type build_mod_tab(input int unsigned g);
      coord_tab_type t;
      int unsigned r;
      r = 0;
      for (int unsigned i = 0; i < POS_N; i++) begin
         t[i] = 8'(r);
         if (r == g - 1) begin
            r = 0;
         end else begin
            r = r + 1;
         end
      end
      return t;
   endfunction

   localparam coord_tab_type MOD_X_TAB = build_mod_tab(GRID_X);
   localparam coord_tab_type MOD_Y_TAB = build_mod_tab(GRID_Y);
   localparam coord_tab_type MOD_Z_TAB = build_mod_tab(GRID_Z);

   typedef struct packed {
      logic          valid;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [ZW-1:0] z;
   } issue_type;

   typedef struct packed {
      logic          valid;
      logic [AW-1:0] addr;
   } addr_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] data;
   } word_type;

   typedef struct packed {
      logic                done;
      logic [ENERGY_W-1:0] energy;
   } energy_type;

endpackage

// ----- rtl/core/periodic_gradient_energy_3d_top.sv -----
// Top level of the periodic gradient energy block: command sequencer, field memory and ports.
// It depends on pgrad_pkg, pgrad_ram, pgrad_addr, pgrad_accum and assert_macros.svh.
//
// Both fields of a voxel share one 32-bit memory word, and the block handles one beat at a
// time. A load beat issues the voxel coordinates and passes the two address stages before
// the write. A query beat issues six neighbor reads, one per cycle through the single read
// port, followed by the two address stages, the registered read, the square stage, the final
// sum and the hand-over of the sum to the output register once that register is free.
// The result waits in an output register, so the next beat is accepted while it is pending.
// The memory is not cleared after reset; a query must only touch voxels loaded before it.
module periodic_gradient_energy_3d_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pos_x, pos_y, pos_z, value_a, value_b, zero fill
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // energy, zero fill
);
   import pgrad_pkg::*;
   `include "assert_macros.svh"

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_ISSUE  = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_RESULT = 2'd3;

   localparam logic [2:0] STEP_XP = 3'd0;
   localparam logic [2:0] STEP_XM = 3'd1;
   localparam logic [2:0] STEP_YP = 3'd2;
   localparam logic [2:0] STEP_YM = 3'd3;
   localparam logic [2:0] STEP_ZP = 3'd4;
   localparam logic [2:0] STEP_ZM = 3'd5;

   logic [1:0]          state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic                cmd_ff;
   logic [XW-1:0]       x_ff, xp, xm;
   logic [YW-1:0]       y_ff, yp, ym;
   logic [ZW-1:0]       z_ff, zp, zm;
   logic [WORD_W-1:0]   word_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0] rsp_data_ff;
   logic                rd_valid_ff;
   logic                accept, start, load_rsp, wr_en, rd_en;
   logic [WORD_W-1:0]   rd_data;
   issue_type           issue;
   addr_type            addr;
   word_type            word;
   energy_type          result;

   assign accept   = req_tvalid && req_tready;
   assign start    = accept && (req_tuser == CMD_QUERY);
   assign load_rsp = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      xp = (x_ff == XW'(GRID_X - 1)) ? '0 : XW'(x_ff + 1'b1);
      xm = (x_ff == '0) ? XW'(GRID_X - 1) : XW'(x_ff - 1'b1);
      yp = (y_ff == YW'(GRID_Y - 1)) ? '0 : YW'(y_ff + 1'b1);
      ym = (y_ff == '0) ? YW'(GRID_Y - 1) : YW'(y_ff - 1'b1);
      zp = (z_ff == ZW'(GRID_Z - 1)) ? '0 : ZW'(z_ff + 1'b1);
      zm = (z_ff == '0) ? ZW'(GRID_Z - 1) : ZW'(z_ff - 1'b1);

      issue.valid = (state_ff == S_ISSUE);
      issue.x     = x_ff;
      issue.y     = y_ff;
      issue.z     = z_ff;
      if (cmd_ff == CMD_QUERY) begin
         case (step_ff)
            STEP_XP: issue.x = xp;
            STEP_XM: issue.x = xm;
            STEP_YP: issue.y = yp;
            STEP_YM: issue.y = ym;
            STEP_ZP: issue.z = zp;
            STEP_ZM: issue.z = zm;
            default: issue.x = x_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_ISSUE;
               step_in  = STEP_XP;
            end
         end
         S_ISSUE: begin
            if (cmd_ff == CMD_LOAD || step_ff == STEP_ZM) begin
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_DRAIN: begin
            if (cmd_ff == CMD_LOAD && addr.valid) begin
               state_in = S_IDLE;
            end else if (cmd_ff == CMD_QUERY && result.done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_XP;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_en;
      end
      if (accept) begin
         cmd_ff  <= req_tuser;
         x_ff    <= MOD_X_TAB[req_tdata[5:0]][XW-1:0];
         y_ff    <= MOD_Y_TAB[req_tdata[11:6]][YW-1:0];
         z_ff    <= MOD_Z_TAB[req_tdata[17:12]][ZW-1:0];
         word_ff <= req_tdata[49:18];
      end
      if (load_rsp) begin
         rsp_data_ff <= result.energy;
      end
   end

   assign wr_en = addr.valid && (cmd_ff == CMD_LOAD);
   assign rd_en = addr.valid && (cmd_ff == CMD_QUERY);

   pgrad_addr u_addr (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .addr  (addr)
   );

   pgrad_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELLS)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr.addr),
      .wr_data (word_ff),
      .rd_en   (rd_en),
      .rd_addr (addr.addr),
      .rd_data (rd_data)
   );

   assign word.valid = rd_valid_ff;
   assign word.data  = rd_data;

   pgrad_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .word   (word),
      .result (result)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(40 - ENERGY_W){1'b0}}, rsp_data_ff};

   `PG_ASSERT(a_done_drain, result.done |-> state_ff == S_DRAIN && cmd_ff == CMD_QUERY, "stray sum")
   `PG_ASSERT(a_write_in_drain, wr_en |-> (state_ff == S_DRAIN), "write outside a load drain")
   `PG_ASSERT(a_accept_issues, accept |=> (state_ff == S_ISSUE), "accepted beat not issued")
   `PG_ASSERT_NEVER(a_idle_pipe, (state_ff == S_IDLE) && (addr.valid || rd_valid_ff), "idle access")

endmodule

// ----- rtl/core/pgrad_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// It has no dependencies.
module pgrad_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pgrad_addr.sv -----
// Two-stage voxel address generator: row = z * GRID_X + x, then row * GRID_Y + y.
// It depends on pgrad_pkg.
module pgrad_addr (
   input  logic                 clock,
   input  logic                 reset,
   input  pgrad_pkg::issue_type issue,
   output pgrad_pkg::addr_type  addr
);
   import pgrad_pkg::*;

   logic             v1_ff, v1_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [YW-1:0]    y1_ff;
   logic             v2_ff, v2_in;
   logic [AW-1:0]    addr_ff, addr_in;

   always_comb begin
      v1_in   = issue.valid;
      row_in  = ROW_W'(ROW_W'(issue.z) * ROW_W'(GRID_X) + ROW_W'(issue.x));
      v2_in   = v1_ff;
      addr_in = AW'(AW'(row_ff) * AW'(GRID_Y) + AW'(y1_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      row_ff  <= row_in;
      y1_ff   <= issue.y;
      addr_ff <= addr_in;
   end

   assign addr.valid = v2_ff;
   assign addr.addr  = addr_ff;

endmodule

// ----- rtl/core/pgrad_accum.sv -----
// Pairs neighbor words, squares both field differences and sums three pairs.
// It depends on pgrad_pkg.
module pgrad_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pgrad_pkg::word_type   word,
   output pgrad_pkg::energy_type result
);
   import pgrad_pkg::*;

   logic                     parity_ff, parity_in;
   logic [WORD_W-1:0]        next_ff;
   logic signed [DIFF_W-1:0] diff_a, diff_b;
   logic signed [2*DIFF_W-1:0] prod_a, prod_b;
   logic [SQ_W-1:0]          sq_a_ff, sq_b_ff;
   logic                     sq_valid_ff, sq_valid_in;
   logic [PAIR_W-1:0]        pair_ff, pair_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     done_ff, done_in;
   logic [ENERGY_W-1:0]      energy_ff;

   always_comb begin
      diff_a = $signed({next_ff[VAL_W-1], next_ff[VAL_W-1:0]})
             - $signed({word.data[VAL_W-1], word.data[VAL_W-1:0]});
      diff_b = $signed({next_ff[WORD_W-1], next_ff[WORD_W-1:VAL_W]})
             - $signed({word.data[WORD_W-1], word.data[WORD_W-1:VAL_W]});
      prod_a = diff_a * diff_a;
      prod_b = diff_b * diff_b;

      parity_in   = start ? 1'b0 : (word.valid ? ~parity_ff : parity_ff);
      sq_valid_in = word.valid && parity_ff && !start;

      acc_in  = acc_ff + ACC_W'(sq_a_ff) + ACC_W'(sq_b_ff);
      pair_in = pair_ff;
      done_in = 1'b0;
      if (start) begin
         pair_in = '0;
      end else if (sq_valid_ff) begin
         pair_in = PAIR_W'(pair_ff + 1'b1);
         done_in = (pair_ff == PAIR_W'(NUM_PAIRS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff   <= 1'b0;
         sq_valid_ff <= 1'b0;
         pair_ff     <= '0;
         done_ff     <= 1'b0;
         acc_ff      <= '0;
      end else begin
         parity_ff   <= parity_in;
         sq_valid_ff <= sq_valid_in;
         pair_ff     <= pair_in;
         done_ff     <= done_in;
         if (start) begin
            acc_ff <= '0;
         end else if (sq_valid_ff) begin
            acc_ff <= acc_in;
         end
      end
      if (word.valid && !parity_ff) begin
         next_ff <= word.data;
      end
      sq_a_ff <= prod_a[SQ_W-1:0];
      sq_b_ff <= prod_b[SQ_W-1:0];
      if (done_in) begin
         energy_ff <= ENERGY_W'((acc_in + ACC_W'(ROUND_ADD)) >> FRAC_DROP);
      end
   end

   assign result.done   = done_ff;
   assign result.energy = energy_ff;

endmodule
